// ===== hdl/jpeg_huffman_symbol_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// jpeg huffman symbol decoder assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef JPEG_HUFFMAN_SYMBOL_DECODER_CORE_ASSERT_SVH
`define JPEG_HUFFMAN_SYMBOL_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define JHSD_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jhsd assertion failed");

// next-cycle implication
`define JHSD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jhsd assertion failed");

`endif

// ===== hdl/jhsd_pkg.sv =====
// ----------------------------------------------------------------------------
// jhsd_pkg
// types and constants shared by the huffman symbol decoder modules
// ----------------------------------------------------------------------------
package jhsd_pkg;

   localparam int MAX_CODE_LENGTH = 16;
   localparam int LEN_W           = 4;
   localparam int DEPTH_W         = 5;
   localparam int CODE_W          = 16;
   localparam int FC_W            = 17;
   localparam int VB_W            = 9;
   localparam int ACC_W           = 18;
   localparam int TOTAL_W         = 12;

   typedef enum logic [2:0] {
      REQ_CLEAR  = 3'd0,
      REQ_COUNT  = 3'd1,
      REQ_APPEND = 3'd2,
      REQ_FINISH = 3'd3,
      REQ_BIT    = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_SYMBOL = 2'd1,
      KIND_ERROR  = 2'd2
   } result_kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_COUNT_BIG = 3'd1,
      ST_EXTRA     = 3'd2,
      ST_MISSING   = 3'd3,
      ST_OVERFLOW  = 3'd4
   } build_status_type;

   typedef struct packed {
      logic do_clear;
      logic do_count;
      logic do_append;
      logic do_finish;
      logic do_bit;
      logic build_step;
      logic build_done;
      logic sym_read;
      logic sym_emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic bit_hit;
      logic build_last;
   } ctl_status_type;

endpackage

// ===== hdl/jhsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// jhsd_ctrl
// sequencer: dispatches request beats, runs the table build and symbol read
// ----------------------------------------------------------------------------
module jhsd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_type,
   input  jhsd_pkg::ctl_status_type stat,
   output jhsd_pkg::ctl_cmd_type    cmd
);
   import jhsd_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_BUILD = 5'b00010,
      S_DONE  = 5'b00100,
      S_READ  = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE) && stat.rsp_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_CLEAR:  cmd.do_clear = 1'b1;
                  REQ_COUNT:  cmd.do_count = 1'b1;
                  REQ_APPEND: cmd.do_append = 1'b1;
                  REQ_FINISH: begin
                     cmd.do_finish = 1'b1;
                     state_in      = S_BUILD;
                  end
                  REQ_BIT: begin
                     cmd.do_bit = 1'b1;
                     if (stat.bit_hit) begin
                        state_in = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_BUILD: begin
            cmd.build_step = 1'b1;
            if (stat.build_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.build_done = 1'b1;
            state_in       = S_IDLE;
         end
         S_READ: begin
            cmd.sym_read = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            cmd.sym_emit = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/jhsd_datapath.sv =====
// ----------------------------------------------------------------------------
// jhsd_datapath
// code tables, symbol store, bit walk and result register
// ----------------------------------------------------------------------------
module jhsd_datapath #(
   parameter int MAX_SYMBOLS = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  jhsd_pkg::ctl_cmd_type    cmd,
   output jhsd_pkg::ctl_status_type stat,
   input  logic [3:0]               req_length_index,
   input  logic [7:0]               req_code_count,
   input  logic [7:0]               req_symbol_value,
   input  logic                     req_code_bit,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_result_kind,
   output logic [7:0]               rsp_decoded_symbol,
   output logic [2:0]               rsp_build_status
);
   import jhsd_pkg::*;

   localparam int ADDR_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int LOAD_W = $clog2(MAX_SYMBOLS + 1);

   // table state
   logic [7:0]         counts_ff [MAX_CODE_LENGTH];
   logic [7:0]         counts_in [MAX_CODE_LENGTH];
   logic [FC_W-1:0]    fc_ff     [MAX_CODE_LENGTH];
   logic [FC_W-1:0]    fc_in     [MAX_CODE_LENGTH];
   logic [VB_W-1:0]    vb_ff     [MAX_CODE_LENGTH];
   logic [VB_W-1:0]    vb_in     [MAX_CODE_LENGTH];
   logic [LOAD_W-1:0]  loaded_ff, loaded_in;
   logic               excess_ff, excess_in;
   logic               ready_ff, ready_in;
   logic [DEPTH_W-1:0] top_len_ff, top_len_in;
   logic [CODE_W-1:0]  top_code_ff, top_code_in;

   // build loop
   logic [LEN_W-1:0]   len_idx_ff, len_idx_in;
   logic [ACC_W-1:0]   code_acc_ff, code_acc_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               big_ff, big_in;
   logic               ovf_ff, ovf_in;

   // walk
   logic [CODE_W-1:0]  walk_code_ff, walk_code_in;
   logic [DEPTH_W-1:0] walk_depth_ff, walk_depth_in;
   logic [ADDR_W-1:0]  sym_addr_ff, sym_addr_in;
   logic [7:0]         rd_data_ff;
   logic [7:0]         sym_mem [MAX_SYMBOLS];

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic [7:0]         rsp_sym_ff, rsp_sym_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;

   logic [LEN_W-1:0]   tbl_idx;
   logic [7:0]         cnt_sel;
   logic [FC_W-1:0]    fc_sel;
   logic [VB_W-1:0]    vb_sel;
   logic               store_full;

   logic [DEPTH_W-1:0] step_len;
   logic [FC_W-1:0]    step_pow;
   logic [ACC_W-1:0]   step_sum;
   logic [ACC_W-1:0]   step_top;

   logic [CODE_W-1:0]  bit_code;
   logic [DEPTH_W-1:0] bit_len;
   logic [DEPTH_W-1:0] bit_shift;
   logic [CODE_W-1:0]  bit_limit;
   logic [FC_W-1:0]    bit_diff;
   logic [FC_W-1:0]    bit_addr;
   logic               bit_err;
   logic               bit_hit;

   logic [TOTAL_W-1:0] loaded_ext;
   build_status_type   fin_status;

   // one shared read index for the small tables
   assign tbl_idx = cmd.build_step ? len_idx_ff : walk_depth_ff[LEN_W-1:0];
   assign cnt_sel = counts_ff[tbl_idx];
   assign fc_sel  = fc_ff[tbl_idx];
   assign vb_sel  = vb_ff[tbl_idx];

   assign store_full = (loaded_ff >= LOAD_W'(MAX_SYMBOLS));

   // build step for length len_idx + 1
   assign step_len = {1'b0, len_idx_ff} + DEPTH_W'(1);
   assign step_pow = FC_W'(1) << step_len;
   assign step_sum = code_acc_ff + ACC_W'(cnt_sel);
   assign step_top = step_sum - ACC_W'(1);

   // bit walk
   assign bit_code  = {walk_code_ff[CODE_W-2:0], req_code_bit};
   assign bit_len   = walk_depth_ff + DEPTH_W'(1);
   assign bit_shift = top_len_ff - bit_len;
   assign bit_limit = top_code_ff >> bit_shift;
   assign bit_err   = !ready_ff || (bit_len > top_len_ff) || (bit_code > bit_limit);
   assign bit_diff  = {1'b0, bit_code} - fc_sel;
   assign bit_hit   = !bit_err && ({1'b0, bit_code} >= fc_sel) &&
                      (bit_diff < FC_W'(cnt_sel));
   assign bit_addr  = FC_W'(vb_sel) + bit_diff;

   assign loaded_ext = TOTAL_W'(loaded_ff);

   always_comb begin
      if (big_ff) begin
         fin_status = ST_COUNT_BIG;
      end else if (excess_ff || (loaded_ext > total_ff)) begin
         fin_status = ST_EXTRA;
      end else if (loaded_ext < total_ff) begin
         fin_status = ST_MISSING;
      end else if (ovf_ff) begin
         fin_status = ST_OVERFLOW;
      end else begin
         fin_status = ST_OK;
      end
   end

   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign stat.bit_hit    = bit_hit;
   assign stat.build_last = (len_idx_ff == LEN_W'(MAX_CODE_LENGTH - 1));

   always_comb begin
      counts_in     = counts_ff;
      fc_in         = fc_ff;
      vb_in         = vb_ff;
      loaded_in     = loaded_ff;
      excess_in     = excess_ff;
      ready_in      = ready_ff;
      top_len_in    = top_len_ff;
      top_code_in   = top_code_ff;
      len_idx_in    = len_idx_ff;
      code_acc_in   = code_acc_ff;
      total_in      = total_ff;
      big_in        = big_ff;
      ovf_in        = ovf_ff;
      walk_code_in  = walk_code_ff;
      walk_depth_in = walk_depth_ff;
      sym_addr_in   = sym_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.do_clear || cmd.do_count || cmd.do_append || cmd.do_finish) begin
         ready_in      = 1'b0;
         walk_code_in  = '0;
         walk_depth_in = '0;
      end

      if (cmd.do_clear) begin
         for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
            counts_in[i] = '0;
         end
         loaded_in = '0;
         excess_in = 1'b0;
      end

      if (cmd.do_count) begin
         counts_in[req_length_index] = req_code_count;
      end

      if (cmd.do_append) begin
         if (store_full) begin
            excess_in = 1'b1;
         end else begin
            loaded_in = loaded_ff + LOAD_W'(1);
         end
      end

      if (cmd.do_finish) begin
         len_idx_in  = '0;
         code_acc_in = '0;
         total_in    = '0;
         big_in      = 1'b0;
         ovf_in      = 1'b0;
         top_len_in  = '0;
         top_code_in = '0;
      end

      if (cmd.build_step) begin
         fc_in[len_idx_ff] = code_acc_ff[FC_W-1:0];
         vb_in[len_idx_ff] = total_ff[VB_W-1:0];
         big_in      = big_ff || (FC_W'(cnt_sel) > step_pow);
         ovf_in      = ovf_ff || (step_sum > ACC_W'(step_pow));
         total_in    = total_ff + TOTAL_W'(cnt_sel);
         code_acc_in = {step_sum[ACC_W-2:0], 1'b0};
         len_idx_in  = len_idx_ff + LEN_W'(1);
         if (cnt_sel != 8'd0) begin
            top_len_in  = step_len;
            top_code_in = step_top[CODE_W-1:0];
         end
      end

      if (cmd.build_done) begin
         ready_in      = (fin_status == ST_OK);
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_STATUS;
         rsp_sym_in    = '0;
         rsp_status_in = fin_status;
      end

      if (cmd.do_bit) begin
         if (bit_err || bit_hit) begin
            walk_code_in  = '0;
            walk_depth_in = '0;
         end else begin
            walk_code_in  = bit_code;
            walk_depth_in = bit_len;
         end
         if (bit_err) begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_ERROR;
            rsp_sym_in    = '0;
            rsp_status_in = ST_OK;
         end
         if (bit_hit) begin
            sym_addr_in = bit_addr[ADDR_W-1:0];
         end
      end

      if (cmd.sym_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_SYMBOL;
         rsp_sym_in    = rd_data_ff;
         rsp_status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
            counts_ff[i] <= '0;
            fc_ff[i]     <= '0;
            vb_ff[i]     <= '0;
         end
         loaded_ff     <= '0;
         excess_ff     <= 1'b0;
         ready_ff      <= 1'b0;
         top_len_ff    <= '0;
         top_code_ff   <= '0;
         len_idx_ff    <= '0;
         walk_code_ff  <= '0;
         walk_depth_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         counts_ff     <= counts_in;
         fc_ff         <= fc_in;
         vb_ff         <= vb_in;
         loaded_ff     <= loaded_in;
         excess_ff     <= excess_in;
         ready_ff      <= ready_in;
         top_len_ff    <= top_len_in;
         top_code_ff   <= top_code_in;
         len_idx_ff    <= len_idx_in;
         walk_code_ff  <= walk_code_in;
         walk_depth_ff <= walk_depth_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_acc_ff   <= code_acc_in;
      total_ff      <= total_in;
      big_ff        <= big_in;
      ovf_ff        <= ovf_in;
      sym_addr_ff   <= sym_addr_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_status_ff <= rsp_status_in;
   end

   // symbol store
   always_ff @(posedge clock) begin
      if (cmd.do_append && !store_full) begin
         sym_mem[loaded_ff[ADDR_W-1:0]] <= req_symbol_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sym_read) begin
         rd_data_ff <= sym_mem[sym_addr_ff];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_decoded_symbol = rsp_sym_ff;
   assign rsp_build_status   = rsp_status_ff;

endmodule

// ===== hdl/jpeg_huffman_symbol_decoder_core.sv =====
// ----------------------------------------------------------------------------
// jpeg_huffman_symbol_decoder_core
// canonical huffman table loader, builder and bit-serial symbol decoder
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  req       req_valid/req_ready, req_type, fields    in
//  rsp       rsp_valid/rsp_ready, kind/symbol/status  out
//
//  clear, set-count and append beats keep the sequencer idle; so does a bit beat,
//  unless it completes a code (table match, then symbol store read, then emit)
//  finish runs 16 length steps through the shared table read index, then 1 status step
//  no clearing pass after reset: the symbol store needs none
//  req_ready is low while the result register holds a beat that is not taken
// ----------------------------------------------------------------------------
module jpeg_huffman_symbol_decoder_core #(
   parameter int MAX_SYMBOLS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_type,
   input  logic [3:0] req_length_index,
   input  logic [7:0] req_code_count,
   input  logic [7:0] req_symbol_value,
   input  logic       req_code_bit,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_decoded_symbol,
   output logic [2:0] rsp_build_status
);
   import jhsd_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type stat;

   jhsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   jhsd_datapath #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_length_index   (req_length_index),
      .req_code_count     (req_code_count),
      .req_symbol_value   (req_symbol_value),
      .req_code_bit       (req_code_bit),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_decoded_symbol (rsp_decoded_symbol),
      .rsp_build_status   (rsp_build_status)
   );

endmodule

// ===== hdl/jhsd_checker.sv =====
// ----------------------------------------------------------------------------
// jhsd_checker
// port-level checks on the huffman symbol decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "jpeg_huffman_symbol_decoder_core_assert.svh"

module jhsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [2:0] req_type,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_result_kind,
   input logic [7:0] rsp_decoded_symbol,
   input logic [2:0] rsp_build_status
);
   import jhsd_pkg::*;

   // a stalled result beat holds
   `JHSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_decoded_symbol) && $stable(rsp_build_status))

   // finish beat starts a multi-cycle build
   `JHSD_ASSERT_NEXT(a_finish_busy, clock, reset, req_valid && req_ready && req_type == REQ_FINISH, !req_ready)

   // status beats carry no symbol
   `JHSD_ASSERT_IMPL(a_status_no_sym, clock, reset, rsp_valid && rsp_result_kind == KIND_STATUS, rsp_decoded_symbol == 8'd0)

   // symbol and error beats carry no status
   `JHSD_ASSERT_IMPL(a_decode_no_status, clock, reset, rsp_valid && rsp_result_kind != KIND_STATUS, rsp_build_status == ST_OK)

endmodule

bind jpeg_huffman_symbol_decoder_core jhsd_checker u_jhsd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_type           (req_type),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result_kind    (rsp_result_kind),
   .rsp_decoded_symbol (rsp_decoded_symbol),
   .rsp_build_status   (rsp_build_status)
);
